// ===== rtl/ustd_pkg.sv =====
// Package for the Unix seconds to day-of-year converter: calendar constants,
// reciprocals for the constant dividers and the payload and pipeline types.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package ustd_pkg;

  localparam logic [31:0] SECS_MEAN_YEAR = 32'd31557600;
  localparam logic [31:0] SECS_YEAR      = 32'd31536000;
  localparam logic [31:0] SECS_DAY       = 32'd86400;
  localparam logic [31:0] SECS_HOUR      = 32'd3600;
  localparam logic [31:0] SECS_MIN       = 32'd60;
  localparam logic [31:0] YEAR_SKEW      = 32'd64800;
  localparam logic [11:0] EPOCH_YEAR     = 12'd1970;
  localparam logic [8:0]  LAST_PLAIN_DAY = 9'd364;
  localparam logic [1:0]  LEAP_PHASE     = 2'b10;

  // The century rule drops a leap day at these year estimates.
  localparam logic [7:0] CENTURY_DROP_A = 8'd131;
  localparam logic [7:0] CENTURY_DROP_B = 8'd231;

  // Truncated reciprocals scaled by 2^32: the estimate is low by at most one.
  localparam logic [63:0] RECIP_SCALE     = 64'h1_0000_0000;
  localparam logic [31:0] RECIP_MEAN_YEAR = 32'(RECIP_SCALE / 64'(SECS_MEAN_YEAR));
  localparam logic [31:0] RECIP_YEAR      = 32'(RECIP_SCALE / 64'(SECS_YEAR));
  localparam logic [31:0] RECIP_DAY       = 32'(RECIP_SCALE / 64'(SECS_DAY));
  localparam logic [31:0] RECIP_HOUR      = 32'(RECIP_SCALE / 64'(SECS_HOUR));
  localparam logic [31:0] RECIP_MIN       = 32'(RECIP_SCALE / 64'(SECS_MIN));

  localparam int unsigned QUOT_W = 9;
  localparam logic [QUOT_W-1:0] QUOT_ONE = 9'd1;

  typedef struct packed {
    logic [31:0] unix_seconds;
    logic [19:0] fraction_us;
  } stamp_t;

  typedef struct packed {
    logic [11:0] year_out;
    logic [8:0]  day_of_year;
    logic [4:0]  hour_of_day;
    logic [5:0]  minute_of_hour;
    logic [5:0]  second_of_minute;
    logic [19:0] second_fraction_us;
  } calendar_t;

  // Values that travel alongside the divider chain until the result is packed.
  typedef struct packed {
    logic [19:0] frac;
    logic [31:0] t;
    logic [7:0]  est;
    logic [7:0]  yrs;
    logic [8:0]  day;
    logic [4:0]  hr;
  } side_t;

endpackage

`default_nettype wire

// ===== rtl/ustd_if.sv =====
// Valid/ready channel interfaces for timestamps in and calendar fields out.
// Depends on ustd_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface ustd_in_if;
  logic valid;
  logic ready;
  ustd_pkg::stamp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ustd_out_if;
  logic valid;
  logic ready;
  ustd_pkg::calendar_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/unix_seconds_to_day_of_year_time_core.sv =====
// Converts a Unix seconds count with microsecond fraction into year, day of
// year, hour, minute and second. The stamp channel takes one timestamp per
// transfer; the calendar channel gives one set of fields per timestamp, in
// the order the timestamps arrived.
// Each side carries one transfer per cycle while the output buffer has room.
// A stamp transfer is registered with the year skew added, then passes the
// mean-year divider, the leap-day correction and the year, day, hour and
// minute dividers; the final day fix and packing go straight into the output
// buffer, whose registered head drives the calendar channel.
// The output buffer holds two results. When the receiver stalls and the
// buffer is full, the whole pipeline freezes in place and stamp.ready falls;
// nothing is dropped or repeated. The fraction passes through unchanged.
// A synchronous reset clears every valid bit and empties the buffer; the
// block accepts a timestamp in the cycle after reset is released.
// Depends on ustd_pkg, ustd_if, ustd_cdiv, ustd_leap and ustd_outbuf.
`timescale 1ns / 1ps
`default_nettype none

module unix_seconds_to_day_of_year_time_core (
  input  logic       clk,
  input  logic       rst,
  ustd_in_if.sink    stamp,
  ustd_out_if.source calendar
);

  logic                        en;
  logic                        v0;
  logic [31:0]                 x0;
  ustd_pkg::side_t             side_in0;
  ustd_pkg::side_t             side0;

  logic                        v1;
  logic [ustd_pkg::QUOT_W-1:0] q1;
  ustd_pkg::side_t             side1;

  logic                        v2;
  logic [31:0]                 tl2;
  ustd_pkg::side_t             side2;

  logic                        v3;
  logic [ustd_pkg::QUOT_W-1:0] q3;
  logic [31:0]                 r3;
  ustd_pkg::side_t             side3;
  ustd_pkg::side_t             side3m;

  logic                        v4;
  logic [ustd_pkg::QUOT_W-1:0] q4;
  logic [31:0]                 r4;
  ustd_pkg::side_t             side4;
  ustd_pkg::side_t             side4m;

  logic                        v5;
  logic [ustd_pkg::QUOT_W-1:0] q5;
  logic [31:0]                 r5;
  ustd_pkg::side_t             side5;
  ustd_pkg::side_t             side5m;

  logic                        v6;
  logic [ustd_pkg::QUOT_W-1:0] q6;
  logic [31:0]                 r6;
  ustd_pkg::side_t             side6;

  logic [8:0]                  day_fix;
  ustd_pkg::calendar_t         result;

  assign stamp.ready = en && !rst;

  always_comb begin
    side_in0      = '0;
    side_in0.t    = stamp.data.unix_seconds;
    side_in0.frac = stamp.data.fraction_us;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= stamp.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x0    <= stamp.data.unix_seconds + ustd_pkg::YEAR_SKEW;
      side0 <= side_in0;
    end
  end

  ustd_cdiv u_est_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v0),
    .x         (x0),
    .divisor   (ustd_pkg::SECS_MEAN_YEAR),
    .recip     (ustd_pkg::RECIP_MEAN_YEAR),
    .side_in   (side0),
    .out_valid (v1),
    .q         (q1),
    .r         (),
    .side_out  (side1)
  );

  ustd_leap u_leap (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v1),
    .est       (q1[7:0]),
    .side_in   (side1),
    .out_valid (v2),
    .tl        (tl2),
    .side_out  (side2)
  );

  ustd_cdiv u_year_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .x         (tl2),
    .divisor   (ustd_pkg::SECS_YEAR),
    .recip     (ustd_pkg::RECIP_YEAR),
    .side_in   (side2),
    .out_valid (v3),
    .q         (q3),
    .r         (r3),
    .side_out  (side3)
  );

  always_comb begin
    side3m     = side3;
    side3m.yrs = q3[7:0];
  end

  ustd_cdiv u_day_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .x         (r3),
    .divisor   (ustd_pkg::SECS_DAY),
    .recip     (ustd_pkg::RECIP_DAY),
    .side_in   (side3m),
    .out_valid (v4),
    .q         (q4),
    .r         (r4),
    .side_out  (side4)
  );

  always_comb begin
    side4m     = side4;
    side4m.day = q4;
  end

  ustd_cdiv u_hour_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .x         (r4),
    .divisor   (ustd_pkg::SECS_HOUR),
    .recip     (ustd_pkg::RECIP_HOUR),
    .side_in   (side4m),
    .out_valid (v5),
    .q         (q5),
    .r         (r5),
    .side_out  (side5)
  );

  always_comb begin
    side5m    = side5;
    side5m.hr = q5[4:0];
  end

  ustd_cdiv u_min_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v5),
    .x         (r5),
    .divisor   (ustd_pkg::SECS_MIN),
    .recip     (ustd_pkg::RECIP_MIN),
    .side_in   (side5m),
    .out_valid (v6),
    .q         (q6),
    .r         (r6),
    .side_out  (side6)
  );

  // In a leap year the last plain day index moves on to the leap day.
  always_comb begin
    if (side6.day == ustd_pkg::LAST_PLAIN_DAY && side6.yrs[1:0] == ustd_pkg::LEAP_PHASE &&
        side6.est != side6.yrs) begin
      day_fix = ustd_pkg::LAST_PLAIN_DAY + 9'd1;
    end else begin
      day_fix = side6.day;
    end
    result.year_out           = {4'd0, side6.yrs} + ustd_pkg::EPOCH_YEAR;
    result.day_of_year        = day_fix + 9'd1;
    result.hour_of_day        = side6.hr;
    result.minute_of_hour     = q6[5:0];
    result.second_of_minute   = r6[5:0];
    result.second_fraction_us = side6.frac;
  end

  ustd_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .push     (v6 && en),
    .item     (result),
    .space    (en),
    .calendar (calendar)
  );

endmodule

`default_nettype wire

// ===== rtl/ustd_cdiv.sv =====
// Three-stage divider by a constant: reciprocal estimate, back-multiply,
// single correction. Depends on ustd_pkg for widths and the side-band type.
`timescale 1ns / 1ps
`default_nettype none

module ustd_cdiv (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [31:0]                 x,
  input  logic [31:0]                 divisor,
  input  logic [31:0]                 recip,
  input  ustd_pkg::side_t             side_in,
  output logic                        out_valid,
  output logic [ustd_pkg::QUOT_W-1:0] q,
  output logic [31:0]                 r,
  output ustd_pkg::side_t             side_out
);

  logic                        va;
  logic                        vb;
  logic [31:0]                 xa;
  logic [ustd_pkg::QUOT_W-1:0] qa;
  logic [ustd_pkg::QUOT_W-1:0] qb;
  logic [31:0]                 rb;
  ustd_pkg::side_t             sa;
  ustd_pkg::side_t             sb;
  logic [63:0]                 prod_est;
  logic [31:0]                 prod_back;

  assign prod_est  = {32'd0, x} * {32'd0, recip};
  assign prod_back = {{(32 - ustd_pkg::QUOT_W){1'b0}}, qa} * divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va        <= in_valid;
      vb        <= va;
      out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xa       <= x;
      qa       <= prod_est[32 +: ustd_pkg::QUOT_W];
      sa       <= side_in;
      qb       <= qa;
      rb       <= xa - prod_back;
      sb       <= sa;
      side_out <= sb;
      if (rb >= divisor) begin
        q <= qb + ustd_pkg::QUOT_ONE;
        r <= rb - divisor;
      end else begin
        q <= qb;
        r <= rb;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ustd_leap.sv =====
// Leap-day stage: counts leap days before the year estimate and removes them
// from the seconds count. Depends on ustd_pkg for constants and types.
`timescale 1ns / 1ps
`default_nettype none

module ustd_leap (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [7:0]      est,
  input  ustd_pkg::side_t side_in,
  output logic            out_valid,
  output logic [31:0]     tl,
  output ustd_pkg::side_t side_out
);

  logic [8:0]      est_inc;
  logic [6:0]      quarter;
  logic [6:0]      drop_a;
  logic [6:0]      drop_b;
  logic [6:0]      leaps;
  logic [31:0]     leap_secs;
  ustd_pkg::side_t side_mod;

  always_comb begin
    est_inc   = {1'b0, est} + 9'd1;
    quarter   = est_inc[8:2];
    drop_a    = {6'd0, est >= ustd_pkg::CENTURY_DROP_A};
    drop_b    = {6'd0, est >= ustd_pkg::CENTURY_DROP_B};
    leaps     = quarter - drop_a - drop_b;
    leap_secs = {25'd0, leaps} * ustd_pkg::SECS_DAY;
    side_mod     = side_in;
    side_mod.est = est;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tl       <= side_in.t - leap_secs;
      side_out <= side_mod;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ustd_outbuf.sv =====
// Two-entry output buffer that decouples the pipeline from the receiver.
// Depends on ustd_pkg and the ustd_out_if channel interface.
`timescale 1ns / 1ps
`default_nettype none

module ustd_outbuf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ustd_pkg::calendar_t item,
  output logic                space,
  ustd_out_if.source          calendar
);

  logic [1:0]          count;
  logic [1:0]          count_next;
  logic                take;
  logic                pop;
  ustd_pkg::calendar_t head;
  ustd_pkg::calendar_t tail;

  assign space          = (count != 2'd2);
  assign take           = push && space;
  assign pop            = calendar.valid && calendar.ready;
  assign calendar.valid = (count != 2'd0);
  assign calendar.data  = head;

  always_comb begin
    case ({take, pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (count == 2'd2) begin
        head <= tail;
      end else if (take) begin
        head <= item;
      end
    end else if (take) begin
      if (count == 2'd0) begin
        head <= item;
      end else begin
        tail <= item;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ustd_checker.sv =====
// Port-level checks for the Unix seconds to day-of-year converter, bound to
// the top level. Depends on ustd_pkg and the top level's channel ports.
`timescale 1ns / 1ps
`default_nettype none

module ustd_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input ustd_pkg::calendar_t out_data
);

  a_out_valid_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("calendar valid dropped before its transfer");

  a_out_data_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("calendar payload changed while stalled");

  a_fields_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.hour_of_day <= 5'd23 && out_data.minute_of_hour <= 6'd59 &&
      out_data.second_of_minute <= 6'd59 && out_data.day_of_year >= 9'd1 &&
      out_data.day_of_year <= 9'd366 && out_data.year_out >= 12'd1970 &&
      out_data.year_out <= 12'd2106)
    else $error("calendar field out of its range");

  a_stall_needs_backlog: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("stamp stalled with no result waiting");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown straight after reset");

endmodule

bind unix_seconds_to_day_of_year_time_core ustd_checker u_ustd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (stamp.ready),
  .out_valid (calendar.valid),
  .out_ready (calendar.ready),
  .out_data  (calendar.data)
);

`default_nettype wire
